// ===== design/tmp_pkg.sv =====
`timescale 1ns / 1ps
package tmp_pkg;
    localparam logic [31:0] QMAX = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN_LIMIT = 32'd66;
    localparam logic [31:0] MIN_SMALL = 32'd7;
    localparam logic [15:0] TICK_RESET = 16'd655;
    localparam logic [1:0] KIND_PLAN = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } op_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } ar_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_OUT
    } state_t;

    // plan, stop ramp and move steps of the sequencer
    typedef enum logic [3:0] {
        STEP_TA,
        STEP_ATA,
        STEP_TWODA,
        STEP_PEAK,
        STEP_TPEAK,
        STEP_TCRUISE,
        STEP_TEND,
        STEP_DV,
        STEP_VT,
        STEP_RAMP_POS,
        STEP_CHECK,
        STEP_CRUISE_POS,
        STEP_AT,
        STEP_ACCEL_POS,
        STEP_DEC_AT,
        STEP_DEC_POS
    } step_t;
endpackage

// ===== design/trapezoidal_motion_profile.sv =====
`timescale 1ns / 1ps
// One transaction at a time: the next input is accepted in the cycle after the result leaves.
// Multiply, divide and square root share one bit-serial unit.
// Reset: asynchronous, active low; tick_period returns to 655, the move is idle
// with finished high and all positions, velocities and times zero.
module trapezoidal_motion_profile (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] distance,
    input  logic [30:0] max_velocity,
    input  logic [30:0] max_accel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] position,
    output logic [30:0] velocity,
    output logic        finished,
    output logic [30:0] duration,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    tmp_pkg::state_t st_reg, st_next;
    tmp_pkg::step_t step_reg, step_next;
    logic [31:0] vlim_reg;
    logic [15:0] tick_reg;
    logic [31:0] el_reg, sel_reg, pos_reg, vel_reg, td_reg, acc_reg, pk_reg, ta_reg, tc_reg,
                 tt_reg, sp_reg, sv_reg, t_reg, x_reg, y_reg, z_reg;
    logic stop_reg, done_reg;
    logic [31:0] el_next, sel_next, pos_next, vel_next, td_next, acc_next, pk_next, ta_next,
                 tc_next, tt_next, sp_next, sv_next, t_next, x_next, y_next, z_next;
    logic stop_next, done_next;
    tmp_pkg::ar_cmd_t cmd;
    logic [31:0] ar_a, ar_b, r;
    logic busy;
    logic [32:0] tsum;
    logic [32:0] mag;
    logic [33:0] tot;
    logic signed [34:0] ps;

    tmp_arith u_arith (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .a(ar_a), .b(ar_b),
        .busy(busy), .result(r)
    );

    assign cfg_ready = (st_reg == tmp_pkg::S_IDLE) && !in_valid;
    assign in_stall  = st_reg != tmp_pkg::S_IDLE;
    assign out_valid = st_reg == tmp_pkg::S_OUT;
    assign position  = pos_reg[30:0];
    assign velocity  = vel_reg[30:0];
    assign finished  = done_reg;
    assign duration  = tt_reg[30:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= tmp_pkg::S_IDLE; step_reg <= tmp_pkg::STEP_TA;
            tick_reg <= tmp_pkg::TICK_RESET;
            el_reg <= '0; sel_reg <= '0; pos_reg <= '0; vel_reg <= '0; td_reg <= '0;
            acc_reg <= '0; pk_reg <= '0; ta_reg <= '0; tc_reg <= '0; tt_reg <= '0;
            sp_reg <= '0; sv_reg <= '0; stop_reg <= 1'b0; done_reg <= 1'b1;
        end
        else
        begin
            st_reg <= st_next; step_reg <= step_next;
            if (cfg_valid && cfg_ready)
                tick_reg <= cfg_data;
            el_reg <= el_next; sel_reg <= sel_next; pos_reg <= pos_next; vel_reg <= vel_next;
            td_reg <= td_next; acc_reg <= acc_next; pk_reg <= pk_next; ta_reg <= ta_next;
            tc_reg <= tc_next; tt_reg <= tt_next; sp_reg <= sp_next; sv_reg <= sv_next;
            stop_reg <= stop_next; done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg <= t_next; x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        if (in_valid && !in_stall)
        begin
            vlim_reg <= ({1'b0, max_velocity} < tmp_pkg::MIN_LIMIT)
                        ? tmp_pkg::MIN_LIMIT : {1'b0, max_velocity};
        end
    end

    // sequencer: each step but STEP_CHECK issues to the arith unit, then consumes r
    always_comb
    begin
        st_next = st_reg; step_next = step_reg;
        el_next = el_reg; sel_next = sel_reg; pos_next = pos_reg; vel_next = vel_reg;
        td_next = td_reg; acc_next = acc_reg; pk_next = pk_reg; ta_next = ta_reg;
        tc_next = tc_reg; tt_next = tt_reg; sp_next = sp_reg; sv_next = sv_reg;
        t_next = t_reg; x_next = x_reg; y_next = y_reg; z_next = z_reg;
        stop_next = stop_reg; done_next = done_reg;
        cmd = '{start: 1'b0, op: tmp_pkg::OP_MUL};
        ar_a = '0; ar_b = '0;
        mag = distance[31] ? (33'h1_0000_0000 - {1'b0, distance}) : {1'b0, distance};
        tsum = '0; tot = '0; ps = '0;
        unique case (st_reg)
            tmp_pkg::S_IDLE:
                if (in_valid)
                begin
                    st_next = tmp_pkg::S_OUT;
                    if (kind == tmp_pkg::KIND_PLAN)
                    begin
                        td_next = (mag > 33'h7FFF_FFFF) ? tmp_pkg::QMAX : mag[31:0];
                        acc_next = ({1'b0, max_accel} > tmp_pkg::MIN_LIMIT)
                                   ? {1'b0, max_accel} : tmp_pkg::MIN_LIMIT;
                        el_next = '0; pos_next = '0; vel_next = '0; stop_next = 1'b0;
                        if (((mag > 33'h7FFF_FFFF) ? tmp_pkg::QMAX : mag[31:0])
                            < tmp_pkg::MIN_SMALL)
                        begin
                            tt_next = '0; done_next = 1'b1;
                        end
                        else
                        begin
                            st_next = tmp_pkg::S_ISSUE; step_next = tmp_pkg::STEP_TA;
                        end
                    end
                    else if (kind == tmp_pkg::KIND_TICK && !done_reg)
                    begin
                        st_next = tmp_pkg::S_ISSUE;
                        if (stop_reg)
                        begin
                            tsum = {1'b0, sel_reg} + {17'd0, tick_reg};
                            sel_next = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
                            step_next = tmp_pkg::STEP_TEND;
                        end
                        else
                        begin
                            tsum = {1'b0, el_reg} + {17'd0, tick_reg};
                            el_next = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];
                            t_next = el_next;
                            step_next = tmp_pkg::STEP_CHECK;
                        end
                    end
                    else if (kind == tmp_pkg::KIND_STOP && !done_reg && !stop_reg)
                    begin
                        stop_next = 1'b1; sp_next = pos_reg; sv_next = vel_reg; sel_next = '0;
                        if (vel_reg < tmp_pkg::MIN_SMALL)
                        begin
                            done_next = 1'b1; vel_next = '0;
                        end
                    end
                end
            tmp_pkg::S_ISSUE:
            begin
                cmd.start = 1'b1;
                st_next = tmp_pkg::S_WAIT;
                unique case (step_reg)
                    tmp_pkg::STEP_TA:
                    begin
                        cmd.op = tmp_pkg::OP_DIV; ar_a = vlim_reg; ar_b = acc_reg;
                    end
                    tmp_pkg::STEP_ATA: begin ar_a = acc_reg; ar_b = x_reg; end
                    tmp_pkg::STEP_TWODA: begin ar_a = y_reg; ar_b = x_reg; end
                    tmp_pkg::STEP_PEAK:
                    begin
                        cmd.op = tmp_pkg::OP_SQRT; ar_a = td_reg; ar_b = acc_reg;
                    end
                    tmp_pkg::STEP_TPEAK:
                    begin
                        cmd.op = tmp_pkg::OP_DIV; ar_a = pk_reg; ar_b = acc_reg;
                    end
                    tmp_pkg::STEP_TCRUISE:
                    begin
                        cmd.op = tmp_pkg::OP_DIV; ar_a = td_reg - y_reg; ar_b = vlim_reg;
                    end
                    tmp_pkg::STEP_TEND:
                    begin
                        cmd.op = tmp_pkg::OP_DIV; ar_a = sv_reg; ar_b = acc_reg;
                    end
                    tmp_pkg::STEP_DV, tmp_pkg::STEP_AT, tmp_pkg::STEP_DEC_AT:
                    begin
                        ar_a = acc_reg; ar_b = t_reg;
                    end
                    tmp_pkg::STEP_VT: begin ar_a = sv_reg; ar_b = t_reg; end
                    tmp_pkg::STEP_RAMP_POS, tmp_pkg::STEP_ACCEL_POS, tmp_pkg::STEP_DEC_POS:
                    begin
                        ar_a = x_reg; ar_b = t_reg;
                    end
                    tmp_pkg::STEP_CRUISE_POS:
                    begin
                        ar_a = pk_reg; ar_b = el_reg - ta_reg;
                    end
                    default: begin ar_a = '0; ar_b = '0; end
                endcase
            end
            tmp_pkg::S_WAIT:
                if (!busy)
                begin
                    st_next = tmp_pkg::S_ISSUE;
                    unique case (step_reg)
                        tmp_pkg::STEP_TA:
                        begin
                            x_next = r; step_next = tmp_pkg::STEP_ATA;
                        end
                        tmp_pkg::STEP_ATA:
                        begin
                            y_next = r; step_next = tmp_pkg::STEP_TWODA;
                        end
                        tmp_pkg::STEP_TWODA:
                        begin
                            y_next = r;
                            step_next = (r >= td_reg) ? tmp_pkg::STEP_PEAK
                                                      : tmp_pkg::STEP_TCRUISE;
                        end
                        tmp_pkg::STEP_PEAK:
                        begin
                            pk_next = r; step_next = tmp_pkg::STEP_TPEAK;
                        end
                        tmp_pkg::STEP_TPEAK, tmp_pkg::STEP_TCRUISE:
                        begin
                            if (step_reg == tmp_pkg::STEP_TPEAK)
                            begin
                                ta_next = r; tc_next = '0;
                            end
                            else
                            begin
                                pk_next = vlim_reg; ta_next = x_reg; tc_next = r;
                            end
                            tot = {1'b0, ta_next, 1'b0} + {2'd0, tc_next};
                            tt_next = (tot > 34'h7FFF_FFFF) ? tmp_pkg::QMAX : tot[31:0];
                            done_next = 1'b0;
                            st_next = tmp_pkg::S_OUT;
                        end
                        tmp_pkg::STEP_TEND:
                        begin
                            t_next = (sel_reg >= r) ? r : sel_reg;
                            if (sel_reg >= r)
                            begin
                                vel_next = '0; done_next = 1'b1;
                            end
                            step_next = tmp_pkg::STEP_DV;
                        end
                        tmp_pkg::STEP_DV:
                        begin
                            x_next = r;
                            if (!done_reg)
                                vel_next = (sv_reg > r) ? sv_reg - r : '0;
                            step_next = tmp_pkg::STEP_VT;
                        end
                        tmp_pkg::STEP_VT:
                        begin
                            z_next = r; step_next = tmp_pkg::STEP_RAMP_POS;
                        end
                        tmp_pkg::STEP_RAMP_POS:
                        begin
                            ps = $signed({3'd0, sp_reg}) + $signed({3'd0, z_reg})
                                 - $signed({4'd0, r[31:1]});
                            st_next = tmp_pkg::S_OUT;
                        end
                        tmp_pkg::STEP_CHECK:
                        begin
                            if (el_reg >= tt_reg)
                            begin
                                pos_next = td_reg; vel_next = '0; done_next = 1'b1;
                                st_next = tmp_pkg::S_OUT;
                            end
                            else if (el_reg < ta_reg)
                                step_next = tmp_pkg::STEP_AT;
                            else if ({1'b0, el_reg} < {1'b0, ta_reg} + {1'b0, tc_reg})
                            begin
                                t_next = ta_reg; step_next = tmp_pkg::STEP_AT;
                            end
                            else
                            begin
                                t_next = tt_reg - el_reg; step_next = tmp_pkg::STEP_DEC_AT;
                            end
                        end
                        tmp_pkg::STEP_CRUISE_POS:
                        begin
                            ps = $signed({3'd0, z_reg}) + $signed({3'd0, r});
                            vel_next = pk_reg; st_next = tmp_pkg::S_OUT;
                        end
                        tmp_pkg::STEP_AT:
                        begin
                            x_next = r;
                            if (el_reg < ta_reg)
                                vel_next = r;
                            step_next = tmp_pkg::STEP_ACCEL_POS;
                        end
                        tmp_pkg::STEP_ACCEL_POS:
                        begin
                            if (el_reg < ta_reg)
                            begin
                                ps = $signed({4'd0, r[31:1]}); st_next = tmp_pkg::S_OUT;
                            end
                            else
                            begin
                                z_next = {1'b0, r[31:1]}; step_next = tmp_pkg::STEP_CRUISE_POS;
                            end
                        end
                        tmp_pkg::STEP_DEC_AT:
                        begin
                            x_next = r; vel_next = r; step_next = tmp_pkg::STEP_DEC_POS;
                        end
                        tmp_pkg::STEP_DEC_POS:
                        begin
                            ps = $signed({3'd0, td_reg}) - $signed({4'd0, r[31:1]});
                            st_next = tmp_pkg::S_OUT;
                        end
                        default:
                            st_next = tmp_pkg::S_OUT;
                    endcase
                    if (step_reg == tmp_pkg::STEP_RAMP_POS
                        || step_reg == tmp_pkg::STEP_CRUISE_POS
                        || step_reg == tmp_pkg::STEP_DEC_POS
                        || (step_reg == tmp_pkg::STEP_ACCEL_POS && el_reg < ta_reg))
                    begin
                        if (ps < 0)
                            pos_next = '0;
                        else if (ps > $signed({3'd0, td_reg}))
                            pos_next = td_reg;
                        else
                            pos_next = ps[31:0];
                    end
                end
            tmp_pkg::S_OUT:
                if (!out_stall)
                    st_next = tmp_pkg::S_IDLE;
            default:
                st_next = tmp_pkg::S_IDLE;
        endcase
        if (step_reg == tmp_pkg::STEP_CHECK && st_reg == tmp_pkg::S_ISSUE)
        begin
            cmd.start = 1'b0; st_next = tmp_pkg::S_WAIT;
        end
    end
endmodule

// ===== design/tmp_arith.sv =====
`timescale 1ns / 1ps
// shared bit-serial unit: one bit per cycle; square root forms its radicand serially first
module tmp_arith (
    input  logic             clk,
    input  logic             rst_n,
    input  tmp_pkg::ar_cmd_t cmd,
    input  logic [31:0]      a,
    input  logic [31:0]      b,
    output logic             busy,
    output logic [31:0]      result
);
    logic [6:0]  cnt_reg, cnt_next;
    tmp_pkg::op_t op_reg, op_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] sh_reg, sh_next;
    logic [64:0] rem_reg, rem_next;
    logic [32:0] q_reg, q_next;
    logic [31:0] b_reg, b_next;
    logic [64:0] trial;
    logic [34:0] strial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            op_reg  <= tmp_pkg::OP_MUL;
        end
        else
        begin
            cnt_reg <= cnt_next;
            op_reg  <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
        q_reg   <= q_next;
        b_reg   <= b_next;
    end

    assign busy = cnt_reg != 7'd0;

    always_comb
    begin
        cnt_next = cnt_reg;
        op_next  = op_reg;
        acc_next = acc_reg;
        sh_next  = sh_reg;
        rem_next = rem_reg;
        q_next   = q_reg;
        b_next   = b_reg;
        trial    = '0;
        strial   = '0;
        if (cmd.start)
        begin
            op_next = cmd.op;
            b_next  = b;
            acc_next = '0;
            rem_next = '0;
            q_next   = '0;
            unique case (cmd.op)
                tmp_pkg::OP_MUL:
                begin
                    sh_next  = {32'd0, a};
                    cnt_next = 7'd32;
                end
                tmp_pkg::OP_DIV:
                begin
                    sh_next  = {16'd0, a, 16'd0};
                    cnt_next = 7'd48;
                end
                default:
                begin
                    sh_next  = {32'd0, a};
                    cnt_next = 7'd64;
                end
            endcase
        end
        else if (cnt_reg != 7'd0)
        begin
            cnt_next = cnt_reg - 7'd1;
            unique case (op_reg)
                tmp_pkg::OP_MUL:
                begin
                    if (sh_reg[cnt_reg[4:0] - 5'd1 + 5'd0] == 1'b0)
                        acc_next = acc_reg << 1;
                    else
                        acc_next = (acc_reg << 1) + {32'd0, b_reg};
                end
                tmp_pkg::OP_DIV:
                begin
                    trial = {rem_reg[63:0], sh_reg[47]};
                    sh_next = sh_reg << 1;
                    if (trial >= {33'd0, b_reg})
                    begin
                        rem_next = trial - {33'd0, b_reg};
                        acc_next = {acc_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial;
                        acc_next = {acc_reg[62:0], 1'b0};
                    end
                end
                default:
                begin
                    if (cnt_reg > 7'd32)
                    begin
                        if (sh_reg[cnt_reg[4:0] - 5'd1] == 1'b0)
                            acc_next = acc_reg << 1;
                        else
                            acc_next = (acc_reg << 1) + {32'd0, b_reg};
                        if (cnt_reg == 7'd33)
                            sh_next = acc_next;
                    end
                    else
                    begin
                        rem_next = {rem_reg[62:0], sh_reg[63:62]};
                        sh_next  = sh_reg << 2;
                        strial   = {q_reg, 2'b01};
                        if ({rem_reg[62:0], sh_reg[63:62]} >= {30'd0, strial})
                        begin
                            rem_next = {rem_reg[62:0], sh_reg[63:62]} - {30'd0, strial};
                            q_next   = {q_reg[31:0], 1'b1};
                        end
                        else
                            q_next = {q_reg[31:0], 1'b0};
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (op_reg)
            tmp_pkg::OP_MUL:
                result = (acc_reg[63:16] > 48'h7FFF_FFFF) ? tmp_pkg::QMAX : acc_reg[47:16];
            tmp_pkg::OP_DIV:
                result = (b_reg == 32'd0 || acc_reg > 64'h7FFF_FFFF)
                         ? tmp_pkg::QMAX : acc_reg[31:0];
            default:
                result = q_reg[31:0];
        endcase
    end
endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
module tb;
    localparam logic [1:0] KIND_NONE = 2'd3;
    localparam logic [31:0] QSAT = 32'h7FFF_FFFF;

    typedef struct {
        logic [30:0] pos;
        logic [30:0] vel;
        logic        fin;
        logic [30:0] dur;
    } motion_sample_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  kind;
    logic [31:0] distance;
    logic [30:0] max_velocity;
    logic [30:0] max_accel;
    logic        out_valid;
    logic        out_stall;
    logic [30:0] position;
    logic [30:0] velocity;
    logic        finished;
    logic [30:0] duration;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    trapezoidal_motion_profile dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .kind(kind), .distance(distance), .max_velocity(max_velocity), .max_accel(max_accel),
        .out_valid(out_valid), .out_stall(out_stall),
        .position(position), .velocity(velocity), .finished(finished), .duration(duration),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // profile state mirror
    logic [15:0] m_tick;
    logic [31:0] m_elapsed, m_stop_elapsed, m_pos, m_vel, m_dist, m_accel, m_peak;
    logic [31:0] m_ta, m_tc, m_total, m_stop_pos, m_stop_vel;
    logic        m_stopping, m_done;

    motion_sample_t expected_samples[$];
    int          mismatches;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic        recv_hold;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #60ms;
        $display("FAILURE");
        $finish;
    end

    function automatic logic [31:0] sat_q(logic [63:0] x);
        return (x > 64'(QSAT)) ? QSAT : x[31:0];
    endfunction

    function automatic logic [31:0] q_mul(logic [31:0] x, logic [31:0] y);
        logic [63:0] p;
        p = 64'(x) * 64'(y);
        return sat_q(p >> 16);
    endfunction

    function automatic logic [31:0] q_div(logic [31:0] x, logic [31:0] y);
        if (y == 0)
        begin
            return QSAT;
        end
        return sat_q((64'(x) << 16) / 64'(y));
    endfunction

    function automatic logic [31:0] floor_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res[31:0];
    endfunction

    function automatic logic [31:0] half_accel_sq(logic [31:0] a, logic [31:0] t);
        return q_mul(q_mul(a, t), t) >> 1;
    endfunction

    function automatic logic [31:0] clamp_travel(longint s);
        if (s < 0)
        begin
            return 0;
        end
        if (s > longint'(m_dist))
        begin
            return m_dist;
        end
        return s[31:0];
    endfunction

    function automatic logic [31:0] sat_time(logic [31:0] base);
        logic [32:0] s;
        s = 33'(base) + 33'(m_tick);
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic void reset_profile();
        m_tick = tmp_pkg::TICK_RESET;
        {m_elapsed, m_stop_elapsed, m_pos, m_vel, m_dist, m_accel} = '0;
        {m_peak, m_ta, m_tc, m_total, m_stop_pos, m_stop_vel} = '0;
        m_stopping = 1'b0;
        m_done = 1'b1;
    endfunction

    function automatic void plan_move(logic [31:0] d, logic [30:0] vmax, logic [30:0] amax);
        logic [63:0] mag;
        logic [31:0] v;
        logic [31:0] ta;
        logic [31:0] twoda;
        mag = d[31] ? ((64'd1 << 32) - 64'(d)) : 64'(d);
        v = 32'(vmax);
        m_dist = sat_q(mag);
        m_accel = (32'(amax) > tmp_pkg::MIN_LIMIT) ? 32'(amax) : tmp_pkg::MIN_LIMIT;
        if (v < tmp_pkg::MIN_LIMIT) v = tmp_pkg::MIN_LIMIT;
        m_elapsed = 0;
        m_pos = 0;
        m_vel = 0;
        m_stopping = 1'b0;
        if (m_dist < tmp_pkg::MIN_SMALL)
        begin
            m_total = 0;
            m_done = 1'b1;
            return;
        end
        ta = q_div(v, m_accel);
        twoda = q_mul(q_mul(m_accel, ta), ta);
        if (twoda >= m_dist)
        begin
            m_peak = floor_sqrt(64'(m_dist) * 64'(m_accel));
            m_ta = q_div(m_peak, m_accel);
            m_tc = 0;
        end
        else
        begin
            m_peak = v;
            m_ta = ta;
            m_tc = q_div(m_dist - twoda, v);
        end
        m_total = sat_q(2 * 64'(m_ta) + 64'(m_tc));
        m_done = 1'b0;
    endfunction

    function automatic void advance_tick();
        logic [31:0] a;
        logic [31:0] t;
        logic [31:0] tend;
        logic [31:0] dv;
        a = m_accel;
        if (m_done)
        begin
            return;
        end
        if (m_stopping)
        begin
            tend = q_div(m_stop_vel, a);
            m_stop_elapsed = sat_time(m_stop_elapsed);
            t = m_stop_elapsed;
            if (t >= tend)
            begin
                t = tend;
                m_vel = 0;
                m_done = 1'b1;
            end
            else
            begin
                dv = q_mul(a, t);
                m_vel = (m_stop_vel > dv) ? m_stop_vel - dv : 0;
            end
            m_pos = clamp_travel(longint'(m_stop_pos) + longint'(q_mul(m_stop_vel, t))
                                 - longint'(half_accel_sq(a, t)));
            return;
        end
        m_elapsed = sat_time(m_elapsed);
        t = m_elapsed;
        if (t >= m_total)
        begin
            m_pos = m_dist;
            m_vel = 0;
            m_done = 1'b1;
        end
        else if (t < m_ta)
        begin
            m_pos = clamp_travel(longint'(half_accel_sq(a, t)));
            m_vel = q_mul(a, t);
        end
        else if (64'(t) < 64'(m_ta) + 64'(m_tc))
        begin
            m_pos = clamp_travel(longint'(half_accel_sq(a, m_ta))
                                 + longint'(q_mul(m_peak, t - m_ta)));
            m_vel = m_peak;
        end
        else
        begin
            t = m_total - t;
            m_pos = clamp_travel(longint'(m_dist) - longint'(half_accel_sq(a, t)));
            m_vel = q_mul(a, t);
        end
    endfunction

    function automatic void begin_stop();
        if (m_done || m_stopping)
        begin
            return;
        end
        m_stopping = 1'b1;
        m_stop_pos = m_pos;
        m_stop_vel = m_vel;
        m_stop_elapsed = 0;
        if (m_stop_vel < tmp_pkg::MIN_SMALL)
        begin
            m_done = 1'b1;
            m_vel = 0;
        end
    endfunction

    function automatic motion_sample_t predict_sample(logic [1:0] k, logic [31:0] d,
                                                      logic [30:0] v, logic [30:0] a);
        motion_sample_t s;
        if (k == tmp_pkg::KIND_PLAN) plan_move(d, v, a);
        else if (k == tmp_pkg::KIND_TICK) advance_tick();
        else if (k == tmp_pkg::KIND_STOP) begin_stop();
        s.pos = m_pos[30:0];
        s.vel = m_vel[30:0];
        s.fin = m_done;
        s.dur = m_total[30:0];
        return s;
    endfunction

    always @(posedge clk)
    begin
        if (recv_hold) out_stall <= 1'b1;
        else out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        motion_sample_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_samples.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result pos=%h vel=%h fin=%b dur=%h",
                             position, velocity, finished, duration);
            end
            else
            begin
                e = expected_samples.pop_front();
                if (position !== e.pos || velocity !== e.vel || finished !== e.fin
                    || duration !== e.dur)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp pos=%h vel=%h fin=%b dur=%h got %h %h %b %h",
                                 e.pos, e.vel, e.fin, e.dur,
                                 position, velocity, finished, duration);
                end
            end
        end
    end

    task automatic send_item(logic [1:0] k, logic [31:0] d = 0,
                             logic [30:0] v = 0, logic [30:0] a = 0);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        distance <= d;
        max_velocity <= v;
        max_accel <= a;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_samples.push_back(predict_sample(k, d, v, a));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_samples.size() != 0) @(posedge clk);
    endtask

    task automatic write_tick_period(logic [15:0] val);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        m_tick = val;
    endtask

    task automatic test_directed();
        write_tick_period(tmp_pkg::TICK_RESET);
        send_item(tmp_pkg::KIND_TICK);
        send_item(tmp_pkg::KIND_STOP);
        send_item(KIND_NONE, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_item(tmp_pkg::KIND_PLAN, 32'd3, 31'd100, 31'd100);
        send_item(tmp_pkg::KIND_PLAN, 32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_item(tmp_pkg::KIND_TICK);
        send_item(tmp_pkg::KIND_PLAN, 32'h0001_0000, 31'd0, 31'd0);
        send_item(tmp_pkg::KIND_TICK);
        send_item(tmp_pkg::KIND_PLAN, 32'hFFF0_0000, 31'h0010_0000, 31'h0008_0000);
        repeat (4) send_item(tmp_pkg::KIND_TICK);
        send_item(tmp_pkg::KIND_STOP);
        send_item(tmp_pkg::KIND_STOP);
        repeat (3) send_item(tmp_pkg::KIND_TICK);
        send_item(tmp_pkg::KIND_PLAN, 32'h0100_0000, 31'h0001_0000, 31'h0400_0000);
        send_item(tmp_pkg::KIND_STOP);
        write_tick_period(16'hFFFF);
        send_item(tmp_pkg::KIND_PLAN, 32'h0002_0000, 31'h0004_0000, 31'h0002_0000);
        repeat (4) send_item(tmp_pkg::KIND_TICK);
        write_tick_period(16'd0);
        send_item(tmp_pkg::KIND_PLAN, 32'h0002_0000, 31'h0004_0000, 31'h0002_0000);
        send_item(tmp_pkg::KIND_TICK);
        send_item(tmp_pkg::KIND_STOP);
    endtask

    function automatic logic [31:0] rand_word();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    task automatic run_random_moves(int count);
        int n;
        int ticks;
        logic [31:0] d;
        n = 0;
        while (n < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                send_item(2'($urandom_range(3)), $urandom, 31'($urandom), 31'($urandom));
                n++;
            end
            else
            begin
                d = rand_word();
                if ($urandom_range(1)) d = -d;
                send_item(tmp_pkg::KIND_PLAN, d, 31'(rand_word()), 31'(rand_word()));
                ticks = $urandom_range(1, 24);
                n++;
                for (int i = 0; i < ticks; i++)
                begin
                    if ($urandom_range(15) == 0) send_item(tmp_pkg::KIND_STOP);
                    else send_item(tmp_pkg::KIND_TICK);
                    n++;
                end
            end
        end
    endtask

    task automatic test_backpressure();
        fork
            begin
                recv_hold = 1'b1;
                repeat (800) @(posedge clk);
                recv_hold = 1'b0;
            end
        join_none
        run_random_moves(20);
    endtask

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        kind = tmp_pkg::KIND_PLAN;
        distance = '0;
        max_velocity = '0;
        max_accel = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        recv_hold = 1'b0;
        mismatches = 0;
        send_idle_pct = 34;
        recv_idle_pct = 56;
        reset_profile();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        write_tick_period(tmp_pkg::TICK_RESET);
        test_backpressure();
        run_random_moves(150);

        send_idle_pct = 56;
        recv_idle_pct = 34;
        write_tick_period(16'hFFFF);
        run_random_moves(150);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_tick_period(16'($urandom_range(1, 65534)));
        run_random_moves(100);
        write_tick_period(16'd1);
        run_random_moves(40);

        wait_drained();
        repeat (300) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
